>>> hw/rtl/miller_rabin_primality_test_defines.svh
// Assertion macros used by the checker file of the primality tester.
`ifndef MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_TEST_DEFINES_SVH

// Condition in one cycle implies a condition in the next cycle.
`define MRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies another condition in the same cycle.
`define MRPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mrpt_pkg.sv
package mrpt_pkg;

    // Default width of the candidate number.
    localparam int NUM_WIDTH_DEF = 31;

    // Fixed witness bases; with all twelve the test is exact below 2^32.
    localparam int BASE_COUNT = 12;
    localparam int BASE_W     = 6;
    localparam int BIDX_W     = $clog2(BASE_COUNT);

    localparam logic [BASE_W-1:0] WITNESS [BASE_COUNT] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
        6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

endpackage

>>> hw/rtl/miller_rabin_primality_test.sv
// Channel   | Signals                          | Direction | Payload
// ----------+----------------------------------+-----------+---------------------------
// candidate | in_valid, in_stall, candidate    | in        | NUM_WIDTH-bit number
// result    | out_valid, out_stall, is_prime   | out       | 1 = prime, 0 = composite
//
// Numbers below 2 or equal to a base skip the test: S_CHECK goes straight to S_DONE,
// which registers the verdict, and the next item can be taken back in S_IDLE.
// A full test is paced by the shared shift-add modular multiplier: one multiplier
// bit per cycle, up to two products per exponent bit.
// in_stall is high while an item is being tested; the verdict waits in the output
// register, and a test that ends while it is still held waits for out_stall to drop.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module miller_rabin_primality_test #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_WIDTH-1:0] candidate,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_prime
);
    import mrpt_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int SW = $clog2(W);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SPLIT = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_POW   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_POWNX = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_ROUND = 4'd8;
    localparam logic [3:0] S_BNEXT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // What a finished product is used for.
    localparam logic [1:0] PH_POW_SQ  = 2'd0;
    localparam logic [1:0] PH_POW_MB  = 2'd1;
    localparam logic [1:0] PH_LOOP_SQ = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [W-1:0]      n_reg, n_next;
    logic [W-1:0]      d_reg, d_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [SW-1:0]     bit_reg, bit_next;
    logic [SW-1:0]     mcnt_reg, mcnt_next;
    logic [BIDX_W-1:0] base_reg, base_next;
    logic [W-1:0]      x_reg, x_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      ma_reg, ma_next;
    logic [W-1:0]      mb_reg, mb_next;
    logic              verdict_reg, verdict_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_prime_reg, out_prime_next;

    logic [W-1:0]      nm1;
    logic [W-1:0]      base_ext;
    logic              is_base;
    logic [W+2:0]      t_sum, t_n, t_2n;
    logic [W-1:0]      red;

    assign nm1      = n_reg - W'(1);
    assign base_ext = {{(W-BASE_W){1'b0}}, WITNESS[base_reg]};

    // Compare the candidate with every witness base at once.
    always_comb
    begin
        is_base = 1'b0;
        for (int i = 0; i < BASE_COUNT; i++)
        begin
            if (n_reg == {{(W-BASE_W){1'b0}}, WITNESS[i]})
                is_base = 1'b1;
        end
    end

    // One step of the modular multiplier: acc = (2 * acc + bit * b) mod n.
    // Since acc and b are below n, the sum is below 3n and one of three picks fits.
    always_comb
    begin
        t_sum = {2'b00, acc_reg, 1'b0} + (ma_reg[W-1] ? {3'b000, mb_reg} : '0);
        t_n   = t_sum - {3'b000, n_reg};
        t_2n  = t_sum - {2'b00, n_reg, 1'b0};
        if (!t_2n[W+2])
            red = t_2n[W-1:0];
        else if (!t_n[W+2])
            red = t_n[W-1:0];
        else
            red = t_sum[W-1:0];
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        bit_next       = bit_reg;
        mcnt_next      = mcnt_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;

        // The output register empties when its item is taken.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (n_reg < W'(2))
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (is_base)
                begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    d_next     = nm1;
                    s_next     = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // Strip one factor of two per cycle.
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + SW'(1);
                end
                else
                begin
                    base_next  = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                x_next     = W'(1);
                bit_next   = SW'(W - 1);
                state_next = S_POW;
            end
            S_POW:
            begin
                ma_next    = x_reg;
                mb_next    = x_reg;
                acc_next   = '0;
                mcnt_next  = SW'(W - 1);
                phase_next = PH_POW_SQ;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next = red;
                ma_next  = ma_reg << 1;
                if (mcnt_reg != '0)
                    mcnt_next = mcnt_reg - SW'(1);
                else
                begin
                    // Product complete: hand it to the step that asked for it.
                    x_next = red;
                    case (phase_reg)
                        PH_POW_SQ:
                        begin
                            if (d_reg[bit_reg])
                            begin
                                ma_next    = base_ext;
                                mb_next    = red;
                                acc_next   = '0;
                                mcnt_next  = SW'(W - 1);
                                phase_next = PH_POW_MB;
                            end
                            else
                                state_next = S_POWNX;
                        end
                        PH_POW_MB:
                        begin
                            state_next = S_POWNX;
                        end
                        PH_LOOP_SQ:
                        begin
                            if (red == nm1)
                                state_next = S_BNEXT;
                            else
                                state_next = S_ROUND;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POWNX:
            begin
                if (bit_reg == '0)
                    state_next = S_EVAL;
                else
                begin
                    bit_next   = bit_reg - SW'(1);
                    state_next = S_POW;
                end
            end
            S_EVAL:
            begin
                if (x_reg == W'(1) || x_reg == nm1)
                    state_next = S_BNEXT;
                else
                begin
                    r_next     = SW'(1);
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                // Up to s-1 further squarings looking for n-1.
                if (r_reg < s_reg)
                begin
                    r_next     = r_reg + SW'(1);
                    ma_next    = x_reg;
                    mb_next    = x_reg;
                    acc_next   = '0;
                    mcnt_next  = SW'(W - 1);
                    phase_next = PH_LOOP_SQ;
                    state_next = S_MUL;
                end
                else
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_BNEXT:
            begin
                if (base_reg == BIDX_W'(BASE_COUNT - 1))
                begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    base_next  = base_reg + BIDX_W'(1);
                    state_next = S_BASE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = verdict_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        phase_reg     <= phase_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        s_reg         <= s_next;
        r_reg         <= r_next;
        bit_reg       <= bit_next;
        mcnt_reg      <= mcnt_next;
        base_reg      <= base_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        verdict_reg   <= verdict_next;
        out_prime_reg <= out_prime_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = out_prime_reg;

endmodule

>>> hw/rtl/mrpt_checker.sv
`include "miller_rabin_primality_test_defines.svh"

module mrpt_checker #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [NUM_WIDTH-1:0] candidate,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 is_prime
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // Once an item is taken the block is busy testing it.
    `MRPT_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "not busy after taking an item")

    // No verdict can appear in the cycle after an item is taken.
    `MRPT_ASSERT_NEXT(a_no_instant_result, in_take, !$rose(out_valid), "result appeared too early")

    // A new verdict only appears at the end of a test.
    `MRPT_ASSERT_SAME(a_result_from_test, $rose(out_valid), $past(in_stall), "result without a test in progress")

    // A stalled verdict stays put.
    `MRPT_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(is_prime), "stalled result changed")

    // A waiting candidate stays put.
    `MRPT_ASSERT_NEXT(a_hold_candidate, in_valid && in_stall, $stable(candidate), "stalled candidate changed")

endmodule

bind miller_rabin_primality_test mrpt_checker #(.NUM_WIDTH(NUM_WIDTH)) u_mrpt_checker (.*);
